// File: src/line_crossing_people_counter_macros.svh
// Assertion macros shared by the line crossing people counter RTL.
`ifndef LINE_CROSSING_PEOPLE_COUNTER_MACROS_SVH
`define LINE_CROSSING_PEOPLE_COUNTER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LCPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define LCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lcpc_pkg.sv
// Types and constants of the line crossing people counter.
`timescale 1ns / 1ps

package lcpc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int HIST_DEPTH = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_POSITION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIVE_IS_EXIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TRAVEL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_LENGTH  = 3'd4;

    // Configuration reset values
    localparam logic signed [15:0] LINE_POSITION_RST    = -16'sd200;
    localparam logic                POSITIVE_IS_EXIT_RST = 1'b1;
    localparam logic [14:0]         DEADZONE_RST         = 15'd30;
    localparam logic [15:0]         MIN_TRAVEL_RST       = 16'd120;
    localparam logic [3:0]          COOLDOWN_LENGTH_RST  = 4'd4;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_NEG  = 2'd1,
        SIDE_POS  = 2'd2,
        SIDE_MID  = 2'd3
    } side_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_IN   = 2'd1,
        EV_OUT  = 2'd2
    } event_t;

    typedef struct packed {
        logic [5:0]         track_slot;
        logic               new_track;
        logic signed [15:0] coordinate;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         crossing_event;
        logic signed [15:0] smoothed_coordinate;
        logic [15:0]        in_total;
        logic [15:0]        out_total;
        logic [15:0]        occupancy;
    } out_word_t;

    // Per-slot tracking state
    typedef struct packed {
        logic signed [15:0] hist2;
        logic signed [15:0] hist1;
        logic signed [15:0] hist0;
        logic [1:0]         fill;
        side_t              side;
        logic signed [15:0] arm_pos;
        logic [3:0]         cooldown;
    } slot_state_t;

endpackage

// File: src/line_crossing_people_counter.sv
// Line crossing people counter: per-slot median, side tracking and totals.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one observation word:
//   slot number, new-track flag and axis coordinate. Output channel
//   (out_valid / out_stall / out_data) returns exactly one result word per
//   observation: crossing event, smoothed coordinate and the three totals.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the block is idle; indexes past the register list are ignored.
// Flow: slot state is read from the state memory at the accepting edge,
//   and the decided word is registered into the output register when the
//   decide stage advances.
// Throughput: one observation per cycle unless stalled; a read-modify-write
//   hitting the slot written in the same cycle takes the forwarded state.
// Reset: configuration returns to its defaults, totals clear, and every slot
//   reads as cleared through per-slot valid bits, so no clearing pass runs.
// Stall: while out_stall holds a waiting result word, the decide stage keeps
//   one more observation; in_stall then rises until the output word is taken.
`timescale 1ns / 1ps

`include "line_crossing_people_counter_macros.svh"

module line_crossing_people_counter
    import lcpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    // Configuration registers
    logic signed [15:0] line_position_reg;
    logic               positive_is_exit_reg;
    logic [14:0]        deadzone_reg;
    logic [15:0]        min_travel_reg;
    logic [3:0]         cooldown_length_reg;

    // Slot state memory and valid bits
    slot_state_t        state_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_valid_reg;

    // Decide stage
    logic               s1_valid_reg;
    in_word_t           s1_item_reg;
    slot_state_t        rd_state_reg;
    logic               rd_valid_reg;
    logic               fwd_hit_reg;
    slot_state_t        wb_state_reg;

    // Totals
    logic [15:0]        in_cnt_reg;
    logic [15:0]        out_cnt_reg;
    logic [15:0]        occ_cnt_reg;
    logic [15:0]        in_cnt_next;
    logic [15:0]        out_cnt_next;
    logic [15:0]        occ_cnt_next;

    // Output register
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic               in_accept;
    logic               s1_adv;
    logic [SLOT_W-1:0]  in_slot;
    logic [SLOT_W-1:0]  s1_slot;
    slot_state_t        st_next;
    out_word_t          result;

    assign in_slot   = in_data.track_slot[SLOT_W-1:0];
    assign s1_slot   = s1_item_reg.track_slot[SLOT_W-1:0];
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_position_reg    <= LINE_POSITION_RST;
            positive_is_exit_reg <= POSITIVE_IS_EXIT_RST;
            deadzone_reg         <= DEADZONE_RST;
            min_travel_reg       <= MIN_TRAVEL_RST;
            cooldown_length_reg  <= COOLDOWN_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_POSITION:    line_position_reg    <= cfg_data;
                REG_POSITIVE_IS_EXIT: positive_is_exit_reg <= cfg_data[0];
                REG_DEADZONE:         deadzone_reg         <= cfg_data[14:0];
                REG_MIN_TRAVEL:       min_travel_reg       <= cfg_data;
                REG_COOLDOWN_LENGTH:  cooldown_length_reg  <= cfg_data[3:0];
                default:              ;
            endcase
        end
    end

    // State memory: write back the decided slot, read the incoming slot
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            state_mem[s1_slot] <= st_next;
        end
        if (in_accept)
        begin
            rd_state_reg <= state_mem[in_slot];
        end
    end

    // Mark written slots valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (s1_adv)
        begin
            slot_valid_reg[s1_slot] <= 1'b1;
        end
    end

    // Load the decide stage and capture forwarding from the same-edge write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= slot_valid_reg[in_slot];
                fwd_hit_reg  <= s1_adv && (s1_slot == in_slot);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the stage payload and the last written state
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_adv)
        begin
            wb_state_reg <= st_next;
        end
    end

    // Decide one observation
    always_comb
    begin
        slot_state_t        cur;
        logic signed [15:0] coord;
        logic signed [15:0] lo01;
        logic signed [15:0] hi01;
        logic signed [15:0] med;
        logic signed [16:0] line_lo;
        logic signed [16:0] line_hi;
        logic signed [16:0] med_x;
        logic signed [16:0] arm_delta;
        logic [16:0]        travel;
        side_t              sd;
        logic               is_out;
        logic [1:0]         ev;

        if (fwd_hit_reg)
        begin
            cur = wb_state_reg;
        end
        else if (rd_valid_reg)
        begin
            cur = rd_state_reg;
        end
        else
        begin
            cur = '0;
        end
        if (s1_item_reg.new_track)
        begin
            cur = '0;
        end

        st_next = cur;
        coord   = s1_item_reg.coordinate;

        // Push the coordinate, drop the oldest once full
        case (cur.fill)
            2'd0:
            begin
                st_next.hist0 = coord;
                st_next.fill  = 2'd1;
            end
            2'd1:
            begin
                st_next.hist1 = coord;
                st_next.fill  = 2'd2;
            end
            2'd2:
            begin
                st_next.hist2 = coord;
                st_next.fill  = 2'd3;
            end
            default:
            begin
                st_next.hist0 = cur.hist1;
                st_next.hist1 = cur.hist2;
                st_next.hist2 = coord;
            end
        endcase

        // Median of what is held; upper value of two
        lo01 = (st_next.hist0 < st_next.hist1) ? st_next.hist0 : st_next.hist1;
        hi01 = (st_next.hist0 < st_next.hist1) ? st_next.hist1 : st_next.hist0;
        if (st_next.fill == 2'd1)
        begin
            med = st_next.hist0;
        end
        else if (st_next.fill == 2'd2)
        begin
            med = hi01;
        end
        else if (st_next.hist2 <= lo01)
        begin
            med = lo01;
        end
        else if (st_next.hist2 >= hi01)
        begin
            med = hi01;
        end
        else
        begin
            med = st_next.hist2;
        end

        // Count down the cooldown
        if (cur.cooldown != 4'd0)
        begin
            st_next.cooldown = cur.cooldown - 4'd1;
        end

        // Classify against the line and its neutral band
        line_lo = 17'(line_position_reg) - $signed({2'b00, deadzone_reg});
        line_hi = 17'(line_position_reg) + $signed({2'b00, deadzone_reg});
        med_x   = 17'(med);
        if (med_x <= line_lo)
        begin
            sd = SIDE_NEG;
        end
        else if (med_x >= line_hi)
        begin
            sd = SIDE_POS;
        end
        else
        begin
            sd = SIDE_MID;
        end

        arm_delta = med_x - 17'(cur.arm_pos);
        travel    = arm_delta[16] ? 17'(-arm_delta) : 17'(arm_delta);
        is_out    = (sd == SIDE_POS) ? positive_is_exit_reg : !positive_is_exit_reg;

        ev           = EV_NONE;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        occ_cnt_next = occ_cnt_reg;

        // Arm, follow or count
        if (cur.side == SIDE_NONE)
        begin
            if (sd != SIDE_MID)
            begin
                st_next.side    = sd;
                st_next.arm_pos = med;
            end
        end
        else if (sd != SIDE_MID && sd != cur.side)
        begin
            if (travel >= {1'b0, min_travel_reg} && st_next.cooldown == 4'd0)
            begin
                if (is_out)
                begin
                    ev = EV_OUT;
                    if (out_cnt_reg != CNT_MAX)
                    begin
                        out_cnt_next = out_cnt_reg + 16'd1;
                    end
                    if (occ_cnt_reg != 16'd0)
                    begin
                        occ_cnt_next = occ_cnt_reg - 16'd1;
                    end
                end
                else
                begin
                    ev = EV_IN;
                    if (in_cnt_reg != CNT_MAX)
                    begin
                        in_cnt_next = in_cnt_reg + 16'd1;
                    end
                    if (occ_cnt_reg != CNT_MAX)
                    begin
                        occ_cnt_next = occ_cnt_reg + 16'd1;
                    end
                end
                st_next.cooldown = cooldown_length_reg;
                st_next.side     = sd;
                st_next.arm_pos  = med;
            end
        end
        else if (sd == cur.side)
        begin
            st_next.arm_pos = med;
        end

        result.crossing_event      = ev;
        result.smoothed_coordinate = med;
        result.in_total            = in_cnt_next;
        result.out_total           = out_cnt_next;
        result.occupancy           = occ_cnt_next;
    end

    // Advance totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            occ_cnt_reg <= '0;
        end
        else if (s1_adv)
        begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            occ_cnt_reg <= occ_cnt_next;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    // Checks
    `LCPC_ASSERT(a_event_code, out_valid_reg |-> (out_data_reg.crossing_event == EV_NONE || out_data_reg.crossing_event == EV_IN || out_data_reg.crossing_event == EV_OUT), "bad crossing event code")
    `LCPC_ASSERT_NEXT(a_accept_loads, in_accept, s1_valid_reg, "accepted word not in decide stage")
    `LCPC_ASSERT(a_blocked_stalls, (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall, "input taken while decide stage blocked")
    `LCPC_ASSERT_NEXT(a_adv_gives_out, s1_adv, out_valid_reg, "decided word not presented")

endmodule

// File: verif/line_crossing_people_counter_tb.sv
// Self-checking testbench for the line crossing people counter.
`timescale 1ns / 1ps

module line_crossing_people_counter_tb;
    import lcpc_pkg::*;

    // Index past the register list; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LOG_LIMIT  = 40;
    localparam int NUM_TRACKS = 4;

    // Tracks per-slot crossing state and holds the words the block owes us
    class crossing_scoreboard;
        logic signed [15:0] line_mm;
        logic               exit_on_pos;
        logic [14:0]        dead_band;
        logic [15:0]        travel_min;
        logic [3:0]         cool_len;

        logic signed [15:0] hist [NUM_SLOTS][HIST_DEPTH];
        logic [1:0]         fill [NUM_SLOTS];
        side_t              side [NUM_SLOTS];
        logic signed [15:0] arm_pos [NUM_SLOTS];
        logic [3:0]         cool_left [NUM_SLOTS];
        logic [15:0]        in_cnt;
        logic [15:0]        out_cnt;
        logic [15:0]        occ_cnt;

        out_word_t expected_words [$];
        int        mismatches;

        function new();
            line_mm     = LINE_POSITION_RST;
            exit_on_pos = POSITIVE_IS_EXIT_RST;
            dead_band   = DEADZONE_RST;
            travel_min  = MIN_TRAVEL_RST;
            cool_len    = COOLDOWN_LENGTH_RST;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                for (int k = 0; k < HIST_DEPTH; k++)
                begin
                    hist[s][k] = '0;
                end
                fill[s]      = '0;
                side[s]      = SIDE_NONE;
                arm_pos[s]   = '0;
                cool_left[s] = '0;
            end
            in_cnt     = '0;
            out_cnt    = '0;
            occ_cnt    = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LINE_POSITION:    line_mm     = data;
                REG_POSITIVE_IS_EXIT: exit_on_pos = data[0];
                REG_DEADZONE:         dead_band   = data[14:0];
                REG_MIN_TRAVEL:       travel_min  = data;
                REG_COOLDOWN_LENGTH:  cool_len    = data[3:0];
                default: ;
            endcase
        endfunction

        // Advance one slot by one observation and queue the word it yields
        function void note_observation(in_word_t w);
            int        s;
            int        a;
            int        b;
            int        c;
            int        lo;
            int        hi;
            int        sm;
            int        delta;
            side_t     sd;
            event_t    ev;
            logic      go_out;
            out_word_t want;

            s = int'(w.track_slot) % NUM_SLOTS;
            if (w.new_track)
            begin
                for (int k = 0; k < HIST_DEPTH; k++)
                begin
                    hist[s][k] = '0;
                end
                fill[s]      = '0;
                side[s]      = SIDE_NONE;
                arm_pos[s]   = '0;
                cool_left[s] = '0;
            end

            // Push the coordinate, dropping the oldest once full
            if (fill[s] < HIST_DEPTH)
            begin
                hist[s][fill[s]] = w.coordinate;
                fill[s]          = fill[s] + 2'd1;
            end
            else
            begin
                hist[s][0] = hist[s][1];
                hist[s][1] = hist[s][2];
                hist[s][2] = w.coordinate;
            end

            // Median of what is held; upper value when only two
            a = hist[s][0];
            b = hist[s][1];
            c = hist[s][2];
            case (fill[s])
                2'd1: sm = a;
                2'd2: sm = (a > b) ? a : b;
                default:
                begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    sm = (c <= lo) ? lo : ((c >= hi) ? hi : c);
                end
            endcase

            if (cool_left[s] != 0)
                cool_left[s] = cool_left[s] - 4'd1;

            if (sm <= int'(line_mm) - int'(dead_band))
                sd = SIDE_NEG;
            else if (sm >= int'(line_mm) + int'(dead_band))
                sd = SIDE_POS;
            else
                sd = SIDE_MID;

            // Arm, follow, refuse or count
            ev = EV_NONE;
            if (side[s] == SIDE_NONE)
            begin
                if (sd != SIDE_MID)
                begin
                    side[s]    = sd;
                    arm_pos[s] = sm[15:0];
                end
            end
            else if (sd != SIDE_MID && sd != side[s])
            begin
                delta = sm - int'(arm_pos[s]);
                if (delta < 0)
                    delta = -delta;
                if (delta >= int'(travel_min) && cool_left[s] == 0)
                begin
                    go_out = (sd == SIDE_POS) ? exit_on_pos : !exit_on_pos;
                    if (go_out)
                    begin
                        if (out_cnt != CNT_MAX)
                            out_cnt = out_cnt + 16'd1;
                        if (occ_cnt != 0)
                            occ_cnt = occ_cnt - 16'd1;
                        ev = EV_OUT;
                    end
                    else
                    begin
                        if (in_cnt != CNT_MAX)
                            in_cnt = in_cnt + 16'd1;
                        if (occ_cnt != CNT_MAX)
                            occ_cnt = occ_cnt + 16'd1;
                        ev = EV_IN;
                    end
                    cool_left[s] = cool_len;
                    side[s]      = sd;
                    arm_pos[s]   = sm[15:0];
                end
            end
            else if (sd == side[s])
            begin
                arm_pos[s] = sm[15:0];
            end

            want.crossing_event      = ev;
            want.smoothed_coordinate = sm[15:0];
            want.in_total            = in_cnt;
            want.out_total           = out_cnt;
            want.occupancy           = occ_cnt;
            expected_words.insert(expected_words.size(), want);
        endfunction

        function void report(string field, logic signed [31:0] want_v,
                             logic signed [31:0] got_v);
            mismatches++;
            if (mismatches <= LOG_LIMIT)
                $error("%s: expected %0d, got %0d", field, want_v, got_v);
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_result(out_word_t got);
            out_word_t want;

            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= LOG_LIMIT)
                    $error("result word arrived with no observation pending");
                return;
            end
            want = expected_words[0];
            expected_words.delete(0);
            if (got.crossing_event !== want.crossing_event)
                report("crossing_event", want.crossing_event, got.crossing_event);
            if (got.smoothed_coordinate !== want.smoothed_coordinate)
                report("smoothed_coordinate", want.smoothed_coordinate,
                       got.smoothed_coordinate);
            if (got.in_total !== want.in_total)
                report("in_total", want.in_total, got.in_total);
            if (got.out_total !== want.out_total)
                report("out_total", want.out_total, got.out_total);
            if (got.occupancy !== want.occupancy)
                report("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;

    crossing_scoreboard book = new();

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // Walking tracks for the random part
    int trk_slot [NUM_TRACKS] = '{default: 0};
    int trk_pos  [NUM_TRACKS] = '{default: 0};
    int trk_step [NUM_TRACKS] = '{default: 0};
    int trk_left [NUM_TRACKS] = '{default: 0};
    int trk_jit  [NUM_TRACKS] = '{default: 1};

    line_crossing_people_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver side: stall at random
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(out_data);
    end

    function automatic in_word_t obs(int slot, bit fresh, int coord);
        in_word_t w;

        w.track_slot = slot[5:0];
        w.new_track  = fresh;
        w.coordinate = coord[15:0];
        return w;
    endfunction

    // Mostly tracks that walk across the line, some pure noise
    function automatic in_word_t next_observation();
        logic [31:0] r;
        int          k;
        int          span;
        int          dir;
        int          steps;
        int          c;
        bit          fresh;

        r = $urandom;
        if ($urandom_range(0, 99) < 20)
            return r[$bits(in_word_t)-1:0];

        k     = $urandom_range(0, NUM_TRACKS - 1);
        fresh = 1'b0;
        if (trk_left[k] == 0)
        begin
            span = int'(book.dead_band) + int'(book.travel_min) / 2 + 20;
            if (span > 60000)
                span = 60000;
            dir         = $urandom_range(0, 1) ? 1 : -1;
            steps       = $urandom_range(4, 12);
            trk_slot[k] = $urandom_range(0, NUM_SLOTS - 1);
            trk_pos[k]  = int'(book.line_mm) - dir * span;
            trk_step[k] = dir * ((2 * span) / steps + 1);
            trk_left[k] = steps + $urandom_range(1, 4);
            trk_jit[k]  = span / 8 + 1;
            fresh       = 1'b1;
        end
        else if ($urandom_range(0, 99) < 8)
        begin
            // Turn back to provoke refused and cooldown-blocked crossings
            trk_step[k] = -trk_step[k];
        end

        c = trk_pos[k] + int'($urandom_range(0, 2 * trk_jit[k])) - trk_jit[k];
        c = (c > 32767) ? 32767 : ((c < -32768) ? -32768 : c);
        trk_pos[k]  = trk_pos[k] + trk_step[k];
        trk_left[k] = trk_left[k] - 1;
        return obs(trk_slot[k], fresh, c);
    endfunction

    // Offer one word, hold it until taken; returns at a falling edge
    task automatic send_observation(input in_word_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        book.note_observation(w);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (book.expected_words.size() != 0);
    endtask

    // Stop offering, let every result out and give the pipe time to settle
    task automatic quiesce();
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] line_v, exit_v, dz_v, travel_v,
                                  cool_v);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  regs [5];

        vals = '{line_v, exit_v, dz_v, travel_v, cool_v};
        regs = '{REG_LINE_POSITION, REG_POSITIVE_IS_EXIT, REG_DEADZONE,
                 REG_MIN_TRAVEL, REG_COOLDOWN_LENGTH};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            book.set_register(regs[i], vals[i]);
            @(negedge clk);
        end
        // Hit an index past the list; predictor ignores it as the block must
        cfg_write <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        book.set_register(REG_UNUSED, '1);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                // Hold off until the block has handed back everything
                in_valid <= 1'b0;
                wait_drained();
            end
            send_observation(next_observation());
        end
    endtask

    // Drive one slot neg then pos: a counted crossing every two words
    task automatic run_crossings(input int count);
        int slot;

        for (int i = 0; i < count; i++)
        begin
            slot = $urandom_range(0, NUM_SLOTS - 1);
            send_observation(obs(slot, 1'b1, -int'($urandom_range(1, 1000))));
            send_observation(obs(slot, 1'b0, int'($urandom_range(1, 1000))));
        end
    endtask

    initial
    begin
        in_word_t directed [$];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle_pct   = 25;
        receiver_idle_pct = 51;

        // Reset settings: extremes, deadzone edges, refusals, cooldown, both counts
        directed = '{
            obs(0, 1, -32768), obs(0, 0, 32767),
            obs(1, 1, -230), obs(1, 1, -229), obs(1, 0, -171),
            obs(1, 1, -170), obs(1, 0, -170), obs(1, 0, -300), obs(1, 0, -300),
            obs(2, 1, -240), obs(2, 0, -160), obs(2, 0, -140), obs(2, 0, -100),
            obs(2, 0, -50), obs(2, 0, -1000), obs(2, 0, -1000), obs(2, 0, -1000),
            obs(2, 0, -1000),
            obs(63, 1, 32767), obs(63, 0, -32768), obs(63, 0, 0)
        };
        foreach (directed[i])
            send_observation(directed[i]);
        run_random(100);

        quiesce();
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(170);

        quiesce();
        apply_settings(16'h8000, 16'd1, 16'h7FFF, 16'hFFFF, 16'd15);
        run_random(150);

        sender_idle_pct   = 51;
        receiver_idle_pct = 25;
        quiesce();
        apply_settings(16'h7FFF, 16'd0, 16'd10, 16'd50, 16'd2);
        run_random(170);

        quiesce();
        apply_settings(16'd123, 16'd1, 16'd100, 16'd300, 16'd15);
        run_random(170);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        quiesce();
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        run_random(150);

        quiesce();
        apply_settings(-16'sd500, 16'd0, 16'd5, 16'd20, 16'd1);
        run_random(170);

        // Back-to-back in crossings
        quiesce();
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_crossings(10);

        // Then out crossings, with occupancy falling
        quiesce();
        apply_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        run_crossings(10);

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge clk);
        if (book.mismatches == 0 && book.expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
